FILE: src/mme_pkg.sv
package mme_pkg;

  // Largest matrix dimension and element width (signed fixed point, 16 fraction bits)
  localparam int MAX_DIM     = 8;
  localparam int ELEM_WIDTH  = 32;
  localparam int FRAC_BITS   = 16;

  // Port widths fixed by the interface
  localparam int VALUE_WIDTH     = 32;
  localparam int CFG_WIDTH       = 4;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam int DIM_WIDTH   = $clog2(MAX_DIM + 1);
  localparam int IDX_WIDTH   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_WIDTH  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int COUNT_WIDTH = $clog2(2 * STORE_DEPTH + 1);
  localparam int PROD_WIDTH  = 2 * ELEM_WIDTH;
  localparam int ACC_WIDTH   = PROD_WIDTH + ((MAX_DIM > 1) ? $clog2(MAX_DIM) : 0);

  localparam logic [CFG_WIDTH-1:0] DIM_RESET = CFG_WIDTH'(8);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_A_ROWS    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_B_COLS    = 2'd2
  } reg_index_t;

  // Zero acts as one, anything above MAX_DIM acts as MAX_DIM
  function automatic logic [DIM_WIDTH-1:0] eff_dim(input logic [CFG_WIDTH-1:0] r);
    logic [DIM_WIDTH-1:0] d;
    if (r == '0) begin
      d = DIM_WIDTH'(1);
    end else if (32'(r) > MAX_DIM) begin
      d = DIM_WIDTH'(MAX_DIM);
    end else begin
      d = DIM_WIDTH'(r);
    end
    return d;
  endfunction

endpackage

FILE: src/matrix_multiply_engine_unit.sv
// Channel   Direction  Handshake            Payload
// --------  ---------  -------------------  ------------------------------------------
// element   in         in_valid / in_stall  element_value (signed Q16.16)
// product   out        out_valid/out_stall  product_value (signed Q16.16), last_of_run
// config    in         cfg_we               cfg_index, cfg_data (write only)
//
// Loading takes one word per cycle: M*K words of A, then K*N words of B.
// Each product word then passes through ISSUE, one read of each store RAM per cycle
// over the K pairs, then DRAIN (read data, product, empty-pipe check), then EMIT.
// rst is synchronous: dimensions return to 8, the load position to zero.
// in_stall is high while the product is computed; a stalled result holds the
// output register, and the next result waits in EMIT until it is taken.
module matrix_multiply_engine_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [mme_pkg::VALUE_WIDTH-1:0] element_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [mme_pkg::VALUE_WIDTH-1:0] product_value,
  output logic                                   last_of_run,
  input  logic                                   cfg_we,
  input  logic [mme_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [mme_pkg::CFG_WIDTH-1:0]          cfg_data
);

  typedef enum logic [1:0] {
    LOAD,
    ISSUE,
    DRAIN,
    EMIT
  } state_t;

  localparam int SAT_LSB = mme_pkg::FRAC_BITS + mme_pkg::ELEM_WIDTH - 1;

  state_t state;

  // Configuration registers keep the raw written bits
  logic [mme_pkg::CFG_WIDTH-1:0] a_rows;
  logic [mme_pkg::CFG_WIDTH-1:0] inner_dim;
  logic [mme_pkg::CFG_WIDTH-1:0] b_cols;

  logic [mme_pkg::DIM_WIDTH-1:0]   dim_m;
  logic [mme_pkg::DIM_WIDTH-1:0]   dim_k;
  logic [mme_pkg::DIM_WIDTH-1:0]   dim_n;
  logic [mme_pkg::COUNT_WIDTH-1:0] count_a;
  logic [mme_pkg::COUNT_WIDTH-1:0] count_total;

  logic [mme_pkg::COUNT_WIDTH-1:0] load_count;
  logic [mme_pkg::IDX_WIDTH-1:0]   row;
  logic [mme_pkg::IDX_WIDTH-1:0]   col;
  logic [mme_pkg::DIM_WIDTH-1:0]   step;
  logic [mme_pkg::ADDR_WIDTH-1:0]  a_base;
  logic [mme_pkg::ADDR_WIDTH-1:0]  a_addr;
  logic [mme_pkg::ADDR_WIDTH-1:0]  b_addr;
  logic                            rd_v;
  logic                            prod_v;

  logic signed [mme_pkg::ELEM_WIDTH-1:0] a_q;
  logic signed [mme_pkg::ELEM_WIDTH-1:0] b_q;
  logic signed [mme_pkg::PROD_WIDTH-1:0] prod;
  logic signed [mme_pkg::ACC_WIDTH-1:0]  acc;

  logic                                  load_fire;
  logic                                  load_is_a;
  logic                                  load_last;
  logic [mme_pkg::ADDR_WIDTH-1:0]        wr_addr;
  logic                                  cfg_known;
  logic                                  col_last;
  logic                                  row_last;
  logic                                  out_free;
  logic signed [mme_pkg::ELEM_WIDTH-1:0] sat_value;
  logic [mme_pkg::ACC_WIDTH-1:SAT_LSB]   acc_top;

  assign dim_m       = mme_pkg::eff_dim(a_rows);
  assign dim_k       = mme_pkg::eff_dim(inner_dim);
  assign dim_n       = mme_pkg::eff_dim(b_cols);
  assign count_a     = mme_pkg::COUNT_WIDTH'(dim_m) * mme_pkg::COUNT_WIDTH'(dim_k);
  assign count_total = count_a
                     + mme_pkg::COUNT_WIDTH'(dim_k) * mme_pkg::COUNT_WIDTH'(dim_n);

  // Only LOAD takes words; everything else is compute
  assign in_stall  = (state != LOAD);
  assign load_fire = in_valid && !in_stall;
  assign load_is_a = (load_count < count_a);
  assign load_last = (load_count + mme_pkg::COUNT_WIDTH'(1)) == count_total;
  assign wr_addr   = load_is_a ? mme_pkg::ADDR_WIDTH'(load_count)
                               : mme_pkg::ADDR_WIDTH'(load_count - count_a);

  assign cfg_known = (cfg_index == mme_pkg::REG_A_ROWS) ||
                     (cfg_index == mme_pkg::REG_INNER_DIM) ||
                     (cfg_index == mme_pkg::REG_B_COLS);

  assign col_last = (mme_pkg::DIM_WIDTH'(col) == dim_n - mme_pkg::DIM_WIDTH'(1));
  assign row_last = (mme_pkg::DIM_WIDTH'(row) == dim_m - mme_pkg::DIM_WIDTH'(1));
  assign out_free = !out_valid || !out_stall;

  mme_ram #(
    .WIDTH (mme_pkg::ELEM_WIDTH),
    .DEPTH (mme_pkg::STORE_DEPTH)
  ) u_a_ram (
    .clk   (clk),
    .we    (load_fire && load_is_a),
    .waddr (wr_addr),
    .wdata (element_value[mme_pkg::ELEM_WIDTH-1:0]),
    .raddr (a_addr),
    .rdata (a_q)
  );

  mme_ram #(
    .WIDTH (mme_pkg::ELEM_WIDTH),
    .DEPTH (mme_pkg::STORE_DEPTH)
  ) u_b_ram (
    .clk   (clk),
    .we    (load_fire && !load_is_a),
    .waddr (wr_addr),
    .wdata (element_value[mme_pkg::ELEM_WIDTH-1:0]),
    .raddr (b_addr),
    .rdata (b_q)
  );

  // Drop the fraction (floor) and clamp to the signed element range
  assign acc_top = acc[mme_pkg::ACC_WIDTH-1:SAT_LSB];
  always_comb begin
    if ((&acc_top) || !(|acc_top)) begin
      sat_value = acc[SAT_LSB:mme_pkg::FRAC_BITS];
    end else if (acc[mme_pkg::ACC_WIDTH-1]) begin
      sat_value = {1'b1, {(mme_pkg::ELEM_WIDTH-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(mme_pkg::ELEM_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= LOAD;
      a_rows     <= mme_pkg::DIM_RESET;
      inner_dim  <= mme_pkg::DIM_RESET;
      b_cols     <= mme_pkg::DIM_RESET;
      load_count <= '0;
      rd_v       <= 1'b0;
      prod_v     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Read data returns in the cycle after the address, the product in the cycle after that
      rd_v   <= (state == ISSUE);
      prod_v <= rd_v;

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        LOAD: begin
          acc    <= '0;
          row    <= '0;
          col    <= '0;
          step   <= '0;
          a_base <= '0;
          a_addr <= '0;
          b_addr <= '0;
          if (cfg_we && cfg_known) begin
            // Any known register write restarts loading at the first word of A
            load_count <= '0;
          end else if (load_fire) begin
            if (load_last) begin
              load_count <= '0;
              state      <= ISSUE;
            end else begin
              load_count <= load_count + mme_pkg::COUNT_WIDTH'(1);
            end
          end
        end

        ISSUE: begin
          // Walk row of A and column of B, one pair of reads per cycle
          step   <= step + mme_pkg::DIM_WIDTH'(1);
          a_addr <= a_addr + mme_pkg::ADDR_WIDTH'(1);
          b_addr <= b_addr + mme_pkg::ADDR_WIDTH'(dim_n);
          if (step == dim_k - mme_pkg::DIM_WIDTH'(1)) begin
            state <= DRAIN;
          end
        end

        DRAIN: begin
          if (!rd_v && !prod_v) begin
            state <= EMIT;
          end
        end

        EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            product_value <= mme_pkg::VALUE_WIDTH'(sat_value);
            last_of_run   <= row_last && col_last;
            acc           <= '0;
            step          <= '0;
            if (col_last) begin
              col    <= '0;
              row    <= row + mme_pkg::IDX_WIDTH'(1);
              a_base <= a_base + mme_pkg::ADDR_WIDTH'(dim_k);
              a_addr <= a_base + mme_pkg::ADDR_WIDTH'(dim_k);
              b_addr <= '0;
            end else begin
              col    <= col + mme_pkg::IDX_WIDTH'(1);
              a_addr <= a_base;
              b_addr <= mme_pkg::ADDR_WIDTH'(col) + mme_pkg::ADDR_WIDTH'(1);
            end
            state <= (row_last && col_last) ? LOAD : ISSUE;
          end
        end

        default: begin
          state <= LOAD;
        end
      endcase

      if (cfg_we) begin
        case (cfg_index)
          mme_pkg::REG_A_ROWS:    a_rows    <= cfg_data;
          mme_pkg::REG_INNER_DIM: inner_dim <= cfg_data;
          mme_pkg::REG_B_COLS:    b_cols    <= cfg_data;
          default: begin
          end
        endcase
      end
    end

    // Datapath: multiply stage, then accumulate the exact product
    prod <= a_q * b_q;
    if (prod_v) begin
      acc <= acc + mme_pkg::ACC_WIDTH'(prod);
    end
  end

endmodule

FILE: src/mme_ram.sv
module mme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/mme_checker.sv
module mme_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_stall,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [mme_pkg::VALUE_WIDTH-1:0] product_value,
  input logic                                   last_of_run
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(product_value) && $stable(last_of_run))
    else $error("stalled product word changed or dropped");

  // Reset leaves the block empty and ready to load
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // A word short of the last means the product is still being computed
  a_mid_run_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> in_stall)
    else $error("input taken in the middle of a product run");

  // Taking a word short of the last keeps the input closed, unless the last
  // word moved into the output register at that same edge
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> in_stall || out_valid)
    else $error("product run ended without a last word");

endmodule

bind matrix_multiply_engine_unit mme_checker u_mme_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .product_value (product_value),
  .last_of_run   (last_of_run)
);
